>>> sv/dpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg - shared types and constants for the depth pixel back-projection
// Item types for both channels, register indexes and the pipeline geometry.
// ----------------------------------------------------------------------------
package dpb_pkg;

   // Register indexes on the csr port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTRE_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL_X  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOCAL_Y  = 2'd3;

   localparam logic [15:0] CENTRE_X_RESET = 16'd5120;
   localparam logic [15:0] CENTRE_Y_RESET = 16'd3840;
   localparam logic [15:0] FOCAL_X_RESET  = 16'd8400;
   localparam logic [15:0] FOCAL_Y_RESET  = 16'd8400;

   // |offset| * depth stays below 2^32; the dividend is that product times 16
   localparam int PROD_W   = 32;
   localparam int DIV_BITS = PROD_W + 4;

   // Accept edge to the edge at which the result is taken
   localparam int RSP_LATENCY = DIV_BITS + 4;

   typedef struct packed {
      logic [9:0]  pixel_row;
      logic [9:0]  pixel_col;
      logic [15:0] depth_mm;
   } req_type;

   typedef struct packed {
      logic               point_valid;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        pos_z;
   } rsp_type;

endpackage

>>> sv/depth_pixel_backprojection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection - pinhole back-projection of depth pixels
// Turns a depth pixel (row, column, depth in mm) into a camera-frame point.
// ----------------------------------------------------------------------------
// Usage:
//   An item enters at a rising edge with start high and busy low. busy is
//   high only while reset is held, so a new pixel can enter on every clock.
//   Each result appears on rsp_data for one cycle with rsp_valid high, in
//   input order. Throughput is one item per cycle; the pipeline holds the
//   input, offset and multiply stages, the 36-stage restoring divider (one
//   quotient bit per stage, one per axis) and the saturation stage.
//   pos_x = ((col*16 - principal column) * depth * 16) / focal_x, truncated
//   toward zero and clamped to 32-bit signed; pos_y likewise from the row; a
//   zero depth gives an invalid point with all coordinates zero. A focal
//   register of zero divides by one.
//   Registers are written through csr_we/csr_index/csr_wdata and should only
//   change while no item is in flight. Synchronous reset empties the pipeline
//   (in-flight items are dropped) and loads the register reset values.
//   The receiver cannot stall: rsp_valid is a strobe.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection import dpb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   typedef struct packed {
      logic [15:0]         rem;
      logic [DIV_BITS-1:0] work;
   } div_lane_type;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   function automatic div_lane_type div_step(div_lane_type cur, logic [15:0] dsr);
      logic [16:0]  trial;
      div_lane_type nxt;
      trial    = {cur.rem, cur.work[DIV_BITS-1]};
      nxt.work = {cur.work[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
         nxt.rem     = 16'(trial - {1'b0, dsr});
         nxt.work[0] = 1'b1;
      end else begin
         nxt.rem = trial[15:0];
      end
      return nxt;
   endfunction

   // Clamp a sign and quotient magnitude to 32-bit signed
   function automatic logic [31:0] saturate(logic neg, logic [DIV_BITS-1:0] q);
      logic [31:0] res;
      if (neg) begin
         if (q > DIV_BITS'(36'h0_8000_0000)) res = 32'h8000_0000;
         else                                res = (~q[31:0]) + 32'd1;
      end else begin
         if (|q[DIV_BITS-1:31]) res = 32'h7FFF_FFFF;
         else                   res = q[31:0];
      end
      return res;
   endfunction

   // Configuration registers
   logic [15:0] centre_x_ff, centre_y_ff, focal_x_ff, focal_y_ff;
   logic [15:0] dsr_x, dsr_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         centre_x_ff <= CENTRE_X_RESET;
         centre_y_ff <= CENTRE_Y_RESET;
         focal_x_ff  <= FOCAL_X_RESET;
         focal_y_ff  <= FOCAL_Y_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTRE_X: centre_x_ff <= csr_wdata;
            CSR_CENTRE_Y: centre_y_ff <= csr_wdata;
            CSR_FOCAL_X:  focal_x_ff  <= csr_wdata;
            CSR_FOCAL_Y:  focal_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // zero focal length divides by one
   assign dsr_x = (focal_x_ff == 16'd0) ? 16'd1 : focal_x_ff;
   assign dsr_y = (focal_y_ff == 16'd0) ? 16'd1 : focal_y_ff;

   assign busy = reset;

   // Stage 1: input register
   logic    in_vld_ff;
   req_type in_data_ff;

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= start && !busy;
      in_data_ff <= req_data;
   end

   // Stage 2: offsets from the principal point, split into sign and magnitude
   logic [17:0] off_x, off_y;
   logic        neg_x_in, neg_y_in;
   logic [16:0] mag_x_in, mag_y_in;
   logic        off_vld_ff, neg_x_ff, neg_y_ff;
   logic [16:0] mag_x_ff, mag_y_ff;
   logic [15:0] off_depth_ff;

   always_comb begin
      off_x    = {4'b0, in_data_ff.pixel_col, 4'b0} - {2'b0, centre_x_ff};
      off_y    = {4'b0, in_data_ff.pixel_row, 4'b0} - {2'b0, centre_y_ff};
      neg_x_in = off_x[17];
      neg_y_in = off_y[17];
      mag_x_in = neg_x_in ? 17'((~off_x) + 18'd1) : off_x[16:0];
      mag_y_in = neg_y_in ? 17'((~off_y) + 18'd1) : off_y[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) off_vld_ff <= 1'b0;
      else       off_vld_ff <= in_vld_ff;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      mag_x_ff     <= mag_x_in;
      mag_y_ff     <= mag_y_in;
      off_depth_ff <= in_data_ff.depth_mm;
   end

   // Stage 3: magnitude times depth
   logic [32:0]       prod_x_in, prod_y_in;
   logic              prod_vld_ff, prod_neg_x_ff, prod_neg_y_ff;
   logic [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic [15:0]       prod_depth_ff;

   assign prod_x_in = mag_x_ff * off_depth_ff;
   assign prod_y_in = mag_y_ff * off_depth_ff;

   always_ff @(posedge clock) begin
      if (reset) prod_vld_ff <= 1'b0;
      else       prod_vld_ff <= off_vld_ff;
      prod_neg_x_ff <= neg_x_ff;
      prod_neg_y_ff <= neg_y_ff;
      prod_x_ff     <= prod_x_in[PROD_W-1:0];
      prod_y_ff     <= prod_y_in[PROD_W-1:0];
      prod_depth_ff <= off_depth_ff;
   end

   // Divider stages: one quotient bit per stage and axis
   div_lane_type      lane_x_ff [DIV_BITS];
   div_lane_type      lane_y_ff [DIV_BITS];
   div_lane_type      lane_x_in [DIV_BITS];
   div_lane_type      lane_y_in [DIV_BITS];
   logic [DIV_BITS-1:0] div_vld_ff, div_neg_x_ff, div_neg_y_ff;
   logic [15:0]       div_depth_ff [DIV_BITS];

   always_comb begin
      lane_x_in[0] = div_step('{rem: 16'd0, work: {prod_x_ff, 4'b0}}, dsr_x);
      lane_y_in[0] = div_step('{rem: 16'd0, work: {prod_y_ff, 4'b0}}, dsr_y);
      for (int i = 1; i < DIV_BITS; i++) begin
         lane_x_in[i] = div_step(lane_x_ff[i-1], dsr_x);
         lane_y_in[i] = div_step(lane_y_ff[i-1], dsr_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) div_vld_ff <= '0;
      else       div_vld_ff <= {div_vld_ff[DIV_BITS-2:0], prod_vld_ff};
      div_neg_x_ff    <= {div_neg_x_ff[DIV_BITS-2:0], prod_neg_x_ff};
      div_neg_y_ff    <= {div_neg_y_ff[DIV_BITS-2:0], prod_neg_y_ff};
      div_depth_ff[0] <= prod_depth_ff;
      for (int i = 1; i < DIV_BITS; i++) div_depth_ff[i] <= div_depth_ff[i-1];
      for (int i = 0; i < DIV_BITS; i++) begin
         lane_x_ff[i] <= lane_x_in[i];
         lane_y_ff[i] <= lane_y_in[i];
      end
   end

   // Output stage: saturate, zero out invalid points
   rsp_type rsp_data_in;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_comb begin
      rsp_data_in.point_valid = (div_depth_ff[DIV_BITS-1] != 16'd0);
      rsp_data_in.pos_z       = div_depth_ff[DIV_BITS-1];
      if (rsp_data_in.point_valid) begin
         rsp_data_in.pos_x = saturate(div_neg_x_ff[DIV_BITS-1],
                                      lane_x_ff[DIV_BITS-1].work);
         rsp_data_in.pos_y = saturate(div_neg_y_ff[DIV_BITS-1],
                                      lane_y_ff[DIV_BITS-1].work);
      end else begin
         rsp_data_in.pos_x = '0;
         rsp_data_in.pos_y = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= div_vld_ff[DIV_BITS-1];
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/dpb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_checker - port-level checks for depth_pixel_backprojection
// Latency, one-to-one item flow and invalid-point encoding.
// ----------------------------------------------------------------------------
module dpb_checker import dpb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every accepted item comes out after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("accepted item did not produce a result on time");

   // no result without an accepted item
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("result without a matching item");

   // valid flag follows depth
   a_valid_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.point_valid == (rsp_data.pos_z != 16'd0)))
      else $error("point_valid disagrees with pos_z");

   // invalid points carry zero coordinates
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.point_valid) |->
         (rsp_data.pos_x == 32'sd0 && rsp_data.pos_y == 32'sd0))
      else $error("invalid point with nonzero coordinates");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
